// ----- hdl/mod_p25519_field_alu_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the p25519 field ALU top level
// Each macro expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef MOD_P25519_FIELD_ALU_TOP_ASSERT_SVH
`define MOD_P25519_FIELD_ALU_TOP_ASSERT_SVH

// Same-cycle implication.
`define MPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mpf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_pkg
// Shared constants and types of the p25519 field ALU.
// ----------------------------------------------------------------------------
package mpf_pkg;

  localparam int unsigned FeW  = 256;  // field element width
  localparam int unsigned AccW = 262;  // wide accumulator, holds t_hi*38 + t_lo

  localparam logic [FeW-1:0] PRIME =
    256'h7fffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffed;

  // item action codes
  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_POW = 2'd3;

  typedef enum logic [1:0] {
    ALU_ADD  = 2'd0,  // z = x + y
    ALU_FOLD = 2'd1,  // z = x[255:0] + x[261:256] * 38
    ALU_CSUB = 2'd2,  // z = x >= p ? x - p : x
    ALU_SUBM = 2'd3   // z = (x - y) mod p, both canonical
  } alu_op_e;

  typedef struct packed {
    logic           start;
    logic [FeW-1:0] x;
    logic [FeW-1:0] y;
  } mul_req_t;

endpackage

// ----- hdl/mpf_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_in_if / mpf_out_if
// Valid/ready channels for operand items and result items.
// ----------------------------------------------------------------------------
interface mpf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] operand_a_w0;
  logic [63:0] operand_a_w1;
  logic [63:0] operand_a_w2;
  logic [63:0] operand_a_w3;
  logic [63:0] operand_b_w0;
  logic [63:0] operand_b_w1;
  logic [63:0] operand_b_w2;
  logic [63:0] operand_b_w3;

  modport source (
    output valid, action, operand_a_w0, operand_a_w1, operand_a_w2, operand_a_w3,
           operand_b_w0, operand_b_w1, operand_b_w2, operand_b_w3,
    input  ready
  );
  modport sink (
    input  valid, action, operand_a_w0, operand_a_w1, operand_a_w2, operand_a_w3,
           operand_b_w0, operand_b_w1, operand_b_w2, operand_b_w3,
    output ready
  );
endinterface

interface mpf_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_w0;
  logic [63:0] result_w1;
  logic [63:0] result_w2;
  logic [62:0] result_w3;

  modport source (output valid, result_w0, result_w1, result_w2, result_w3, input ready);
  modport sink   (input valid, result_w0, result_w1, result_w2, result_w3, output ready);
endinterface

// ----- hdl/mod_p25519_field_alu_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mod_p25519_field_alu_top
// Add, subtract, multiply and power in GF(2^255-19) over a shared datapath.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one item = action + operands a, b (four 64-bit words each).
//   out_o : one item = canonical result r < p, four words (top word 63 bits).
//   in_i.ready is high only while the sequencer is idle; one item at a time.
// Steps per action, from accept to result valid:
//   add      add, two folds, two conditional subtracts
//   subtract reduce a and b, modular subtract
//   multiply 64 partial products + 3-step 38x fold + reduction
//   power    256..512 modular products, each through the multiply steps.
//            The single 32x32 multiplier, one partial product per cycle,
//            bounds the time of each product.
// Reset clears the sequencer and the output valid; operand and data
// registers are not reset. A stalled receiver holds the result in the
// output register; the block still accepts the next item meanwhile and only
// waits at the end of that item if the old result is still not taken.
// ----------------------------------------------------------------------------
`include "mod_p25519_field_alu_top_assert.svh"

module mod_p25519_field_alu_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  mpf_in_if.sink    in_i,
  mpf_out_if.source out_o
);
  import mpf_pkg::*;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_ADD    = 5'd1;
  localparam logic [4:0] ST_SA1    = 5'd2;
  localparam logic [4:0] ST_SA2    = 5'd3;
  localparam logic [4:0] ST_SB1    = 5'd4;
  localparam logic [4:0] ST_SB2    = 5'd5;
  localparam logic [4:0] ST_SD     = 5'd6;
  localparam logic [4:0] ST_MSTART = 5'd7;
  localparam logic [4:0] ST_MWAIT  = 5'd8;
  localparam logic [4:0] ST_R1     = 5'd9;
  localparam logic [4:0] ST_R2     = 5'd10;
  localparam logic [4:0] ST_R3     = 5'd11;
  localparam logic [4:0] ST_F1     = 5'd12;
  localparam logic [4:0] ST_F2     = 5'd13;
  localparam logic [4:0] ST_C1     = 5'd14;
  localparam logic [4:0] ST_C2     = 5'd15;
  localparam logic [4:0] ST_PNEXT  = 5'd16;
  localparam logic [4:0] ST_FIN    = 5'd17;

  logic [4:0]      state_q, state_d;
  logic [1:0]      act_q;
  logic [FeW-1:0]  a_q, b_q, acc_q;
  logic [AccW-1:0] s_q;
  logic [7:0]      bit_q;      // exponent bit, MSB first
  logic            sq_q;       // power: square step pending
  logic            accept;

  alu_op_e         alu_op;
  logic [AccW-1:0] alu_x, alu_y, alu_z;

  mul_req_t        mul_req;
  logic            mul_done;
  logic [2*FeW-1:0] prod;
  logic [FeW-1:0]  t_lo, t_hi;

  logic            out_valid_q;
  logic [254:0]    out_q;
  logic            out_load;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign t_lo     = prod[FeW-1:0];
  assign t_hi     = prod[2*FeW-1:FeW];
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_o.ready);

  // Multiplier operands: plain multiply uses a*b, power uses acc*acc or acc*a.
  always_comb begin
    mul_req.start = (state_q == ST_MSTART);
    mul_req.x     = (act_q == ACT_MUL) ? a_q : acc_q;
    mul_req.y     = (act_q == ACT_MUL) ? b_q : (sq_q ? acc_q : a_q);
  end

  mpf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (prod)
  );

  // Operand selection for the shared wide unit.
  always_comb begin
    alu_op = ALU_ADD;
    alu_x  = s_q;
    alu_y  = '0;
    case (state_q)
      ST_ADD: begin
        alu_x = AccW'(a_q);
        alu_y = AccW'(b_q);
      end
      ST_SA1, ST_SA2: begin
        alu_op = ALU_CSUB;
        alu_x  = AccW'(a_q);
      end
      ST_SB1, ST_SB2: begin
        alu_op = ALU_CSUB;
        alu_x  = AccW'(b_q);
      end
      ST_SD: begin
        alu_op = ALU_SUBM;
        alu_x  = AccW'(a_q);
        alu_y  = AccW'(b_q);
      end
      // t_lo + t_hi*38 as t_hi<<5 + t_hi<<2 + t_hi<<1
      ST_R1: begin
        alu_x = AccW'(t_lo);
        alu_y = AccW'({t_hi, 5'd0});
      end
      ST_R2: alu_y = AccW'({t_hi, 2'd0});
      ST_R3: alu_y = AccW'({t_hi, 1'd0});
      ST_F1, ST_F2: alu_op = ALU_FOLD;
      ST_C1, ST_C2: alu_op = ALU_CSUB;
      default: alu_op = ALU_ADD;
    endcase
  end

  mpf_alu u_alu (
    .op_i (alu_op),
    .x_i  (alu_x),
    .y_i  (alu_y),
    .z_o  (alu_z)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_i.action)
            ACT_ADD: state_d = ST_ADD;
            ACT_SUB: state_d = ST_SA1;
            default: state_d = ST_MSTART;
          endcase
        end
      end
      ST_ADD:    state_d = ST_F1;
      ST_SA1:    state_d = ST_SA2;
      ST_SA2:    state_d = ST_SB1;
      ST_SB1:    state_d = ST_SB2;
      ST_SB2:    state_d = ST_SD;
      ST_SD:     state_d = ST_FIN;
      ST_MSTART: state_d = ST_MWAIT;
      ST_MWAIT:  state_d = mul_done ? ST_R1 : ST_MWAIT;
      ST_R1:     state_d = ST_R2;
      ST_R2:     state_d = ST_R3;
      ST_R3:     state_d = ST_F1;
      ST_F1:     state_d = ST_F2;
      ST_F2:     state_d = ST_C1;
      ST_C1:     state_d = ST_C2;
      ST_C2:     state_d = (act_q == ACT_POW) ? ST_PNEXT : ST_FIN;
      ST_PNEXT: begin
        if (sq_q && b_q[bit_q]) begin
          state_d = ST_MSTART;
        end else if (bit_q == 8'd0) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_MSTART;
        end
      end
      ST_FIN:    state_d = out_load ? ST_IDLE : ST_FIN;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          act_q <= in_i.action;
          a_q   <= {in_i.operand_a_w3, in_i.operand_a_w2,
                    in_i.operand_a_w1, in_i.operand_a_w0};
          b_q   <= {in_i.operand_b_w3, in_i.operand_b_w2,
                    in_i.operand_b_w1, in_i.operand_b_w0};
          acc_q <= FeW'(1);
          bit_q <= 8'hFF;
          sq_q  <= 1'b1;
        end
      end
      ST_SA1, ST_SA2: a_q <= alu_z[FeW-1:0];
      ST_SB1, ST_SB2: b_q <= alu_z[FeW-1:0];
      ST_ADD, ST_SD, ST_R1, ST_R2, ST_R3, ST_F1, ST_F2, ST_C1, ST_C2: s_q <= alu_z;
      ST_PNEXT: begin
        acc_q <= s_q[FeW-1:0];
        if (sq_q && b_q[bit_q]) begin
          sq_q <= 1'b0;
        end else begin
          sq_q  <= 1'b1;
          bit_q <= bit_q - 8'd1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_q <= s_q[254:0];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.result_w0 = out_q[63:0];
  assign out_o.result_w1 = out_q[127:64];
  assign out_o.result_w2 = out_q[191:128];
  assign out_o.result_w3 = out_q[254:192];

  // After an accepted item, ready is low in the next cycle.
  `MPF_ASSERT_NXT(a_busy_after_accept, accept, !in_i.ready, "ready stayed high after accept")
  // Results are always canonical, below 2^255-19.
  `MPF_ASSERT_IMP(a_out_canonical, out_o.valid,
    !(out_o.result_w3 == 63'h7fffffffffffffff && out_o.result_w2 == 64'hffffffffffffffff &&
      out_o.result_w1 == 64'hffffffffffffffff && out_o.result_w0 >= 64'hffffffffffffffed),
    "result not reduced below p")
  // A product completes only while the sequencer waits for it.
  `MPF_ASSERT_IMP(a_mul_done_waiting, mul_done, state_q == ST_MWAIT,
    "product finished outside wait state")

endmodule

// ----- hdl/mpf_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_mul
// 256x256 product by column scanning over one 32x32 multiplier.
// ----------------------------------------------------------------------------
module mpf_mul (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mpf_pkg::mul_req_t       req_i,
  output logic                    done_o,
  output logic [2*mpf_pkg::FeW-1:0] prod_o
);
  import mpf_pkg::*;

  logic [7:0][31:0]  x_q, y_q;
  logic              run_q;
  logic [3:0]        k_q;       // column
  logic [2:0]        i_q;       // word of x
  logic [3:0]        j_full;
  logic [2:0]        i_max;
  logic              col_end;
  logic [63:0]       p_q;       // registered partial product
  logic              v_q, last_q;
  logic [3:0]        kcol_q;
  logic [71:0]       acc_q, sum;
  logic [31:0]       t_q [16];
  logic              done_q;

  assign j_full  = k_q - {1'b0, i_q};
  assign i_max   = (k_q > 4'd7) ? 3'd7 : k_q[2:0];
  assign col_end = (i_q == i_max);
  assign sum     = acc_q + {8'd0, p_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      v_q    <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      v_q    <= run_q;
      if (req_i.start && !run_q) begin
        run_q <= 1'b1;
        k_q   <= '0;
        i_q   <= '0;
      end else if (run_q) begin
        if (col_end) begin
          if (k_q == 4'd14) begin
            run_q <= 1'b0;
          end
          k_q <= k_q + 4'd1;
          i_q <= (k_q >= 4'd7) ? 3'(k_q - 4'd6) : 3'd0;
        end else begin
          i_q <= i_q + 3'd1;
        end
      end
      if (v_q && last_q && kcol_q == 4'd14) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !run_q) begin
      x_q   <= req_i.x;
      y_q   <= req_i.y;
      acc_q <= '0;
    end
    p_q    <= 64'(x_q[i_q]) * 64'(y_q[j_full[2:0]]);
    last_q <= col_end;
    kcol_q <= k_q;
    if (v_q) begin
      if (last_q) begin
        t_q[kcol_q] <= sum[31:0];
        acc_q       <= {32'd0, sum[71:32]};
        if (kcol_q == 4'd14) begin
          t_q[15] <= sum[63:32];
        end
      end else begin
        acc_q <= sum;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = {t_q[15], t_q[14], t_q[13], t_q[12], t_q[11], t_q[10], t_q[9], t_q[8],
                   t_q[7], t_q[6], t_q[5], t_q[4], t_q[3], t_q[2], t_q[1], t_q[0]};
endmodule

// ----- hdl/mpf_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_alu
// Shared wide adder: add, fold of 2^256 as 38, conditional subtract of p, modular subtract.
// ----------------------------------------------------------------------------
module mpf_alu (
  input  mpf_pkg::alu_op_e            op_i,
  input  logic [mpf_pkg::AccW-1:0]    x_i,
  input  logic [mpf_pkg::AccW-1:0]    y_i,
  output logic [mpf_pkg::AccW-1:0]    z_o
);
  import mpf_pkg::*;

  logic [11:0]    fold_v;
  logic [FeW:0]   diff;
  logic [FeW-1:0] wrap;

  always_comb begin
    fold_v = 12'(x_i[AccW-1:FeW]) * 12'd38;
    diff   = {1'b0, x_i[FeW-1:0]} - {1'b0, y_i[FeW-1:0]};
    wrap   = diff[FeW-1:0] + PRIME;
    case (op_i)
      ALU_ADD:  z_o = x_i + y_i;
      ALU_FOLD: z_o = AccW'(x_i[FeW-1:0]) + AccW'(fold_v);
      ALU_CSUB: z_o = (x_i >= AccW'(PRIME)) ? x_i - AccW'(PRIME) : x_i;
      ALU_SUBM: z_o = diff[FeW] ? AccW'(wrap) : AccW'(diff[FeW-1:0]);
      default:  z_o = x_i;
    endcase
  end
endmodule
